// ===== hw/rtl/dtpc_pkg.sv =====
// shared types and constants for the depth to point cloud block
// register map, controller commands, depth code to distance table
// no dependencies
`default_nettype none

package dtpc_pkg;

  // register map, index = byte address / 4
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INV_FX = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_FY = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CTR_U  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CTR_V  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd6;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int INV_W   = 24;
  localparam int INV_HALF = 12;
  localparam int CTR_W   = 14;
  localparam int DIM_W   = 11;
  localparam int CODE_W  = 8;
  localparam int COORD_W = 24;
  localparam int DIST_W  = 18;

  localparam logic [INV_W-1:0] INV_F_RST = 24'd223696;
  localparam logic [CTR_W-1:0] CTR_RST   = 14'd800;
  localparam logic [DIM_W-1:0] DIM_RST   = 11'd100;

  localparam logic [CODE_W-1:0] CODE_NONE = 8'hFF;

  localparam longint COORD_MAX = 64'sd8388607;
  localparam longint COORD_MIN = -64'sd8388608;

  // distance = floor((code^2 * 2^16 + DistRound) / DistDiv) in 2^-16 m
  localparam longint DistDiv   = 26010;
  localparam longint DistRound = 13005;

  // multiplier phases within one axis
  localparam logic [1:0] PH_OFF = 2'd0;  // distance times pixel offset
  localparam logic [1:0] PH_LO  = 2'd1;  // partial times low focal half
  localparam logic [1:0] PH_HI  = 2'd2;  // partial times high focal half

  localparam logic AX_H = 1'b0;  // horizontal (y_pos)
  localparam logic AX_V = 1'b1;  // vertical (z_pos)

  typedef struct packed {
    logic             enable;
    logic [INV_W-1:0] inv_fx;
    logic [INV_W-1:0] inv_fy;
    logic [CTR_W-1:0] ctr_u;
    logic [CTR_W-1:0] ctr_v;
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;
  } cfg_t;

  typedef struct packed {
    logic       start;     // request taken, latch pixel and advance position
    logic       mul_en;    // multiplier step this cycle
    logic       axis;
    logic [1:0] phase;
    logic       y_load;    // round horizontal sum into holding register
    logic       out_load;  // round vertical sum, fill output register
  } cmd_t;

  typedef struct packed {
    logic out_blocked;     // output register full and stalled
  } status_t;

  typedef logic [DIST_W-1:0] dist_lut_t [256];

  function automatic dist_lut_t build_dist_lut();
    dist_lut_t t;
    longint    n;
    for (int i = 0; i < 256; i++) begin
      n = longint'(i) * longint'(i) * 65536 + DistRound;
      t[i] = DIST_W'(n / DistDiv);
    end
    return t;
  endfunction

  localparam dist_lut_t DIST_LUT = build_dist_lut();

endpackage

`default_nettype wire

// ===== hw/rtl/depth_to_point_cloud.sv =====
// top level: back-projects 8-bit time-of-flight depth codes to 3-d points
// instantiates dtpc_regs, dtpc_ctrl, dtpc_dp; depends on dtpc_pkg
//
//   port group  | direction | contents
//   ------------+-----------+-------------------------------------------------
//   pixel in    | in        | in_valid/in_stall, depth_code, frame_start
//   point out   | out       | out_valid/out_stall, x_pos, y_pos, z_pos,
//               |           | point_valid, end_of_frame
//   config      | in/out    | apb: psel, penable, pwrite, paddr, pwdata,
//               |           | prdata, pready
//
// an enabled pixel goes through these steps before the input is free again:
// an accept step, six passes of the single shared multiplier (three per
// lateral axis), and a step to round and load the output register
// a pixel while disabled only advances the position
// reset is synchronous; it clears the position counters, the sequencer and
// the output valid, and puts every configuration register back to its reset value
// a stalled output holds the point; the next pixel is still accepted and
// computed, and waits in its last step until the output register frees
`default_nettype none

module depth_to_point_cloud #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // pixel requests
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [dtpc_pkg::CODE_W-1:0]        depth_code,
  input  wire logic                               frame_start,
  // point requests
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [dtpc_pkg::COORD_W-1:0]     x_pos,
  output logic signed [dtpc_pkg::COORD_W-1:0]     y_pos,
  output logic signed [dtpc_pkg::COORD_W-1:0]     z_pos,
  output logic                                    point_valid,
  output logic                                    end_of_frame,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dtpc_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [dtpc_pkg::DATA_W-1:0]        pwdata,
  output logic      [dtpc_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready
);
  import dtpc_pkg::*;

  cfg_t    cfg;     // live register values
  cmd_t    cmd;     // sequencer to datapath
  status_t status;  // datapath to sequencer

  // register file: enable, reciprocal focals, principal point, frame size
  dtpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: one pixel in flight, disabled pixels retire at once
  dtpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .enable   (cfg.enable),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: distance table, -d*offset*inv_focal over the shared
  // multiplier, round half up to 2^-16 m and saturate to 24 bits
  dtpc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .depth_code   (depth_code),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .z_pos        (z_pos),
    .point_valid  (point_valid),
    .end_of_frame (end_of_frame)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dtpc_regs.sv =====
// configuration register file behind an apb-style port
// depends on dtpc_pkg
`default_nettype none

module dtpc_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dtpc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [dtpc_pkg::DATA_W-1:0]    pwdata,
  output logic      [dtpc_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  output dtpc_pkg::cfg_t                      cfg
);
  import dtpc_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.inv_fx <= INV_F_RST;
      cfg.inv_fy <= INV_F_RST;
      cfg.ctr_u  <= CTR_RST;
      cfg.ctr_v  <= CTR_RST;
      cfg.img_w  <= DIM_RST;
      cfg.img_h  <= DIM_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLE: cfg.enable <= pwdata[0];
        REG_INV_FX: cfg.inv_fx <= pwdata[INV_W-1:0];
        REG_INV_FY: cfg.inv_fy <= pwdata[INV_W-1:0];
        REG_CTR_U:  cfg.ctr_u  <= pwdata[CTR_W-1:0];
        REG_CTR_V:  cfg.ctr_v  <= pwdata[CTR_W-1:0];
        REG_WIDTH:  cfg.img_w  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg.img_h  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE: prdata = DATA_W'(cfg.enable);
      REG_INV_FX: prdata = DATA_W'(cfg.inv_fx);
      REG_INV_FY: prdata = DATA_W'(cfg.inv_fy);
      REG_CTR_U:  prdata = DATA_W'(cfg.ctr_u);
      REG_CTR_V:  prdata = DATA_W'(cfg.ctr_v);
      REG_WIDTH:  prdata = DATA_W'(cfg.img_w);
      REG_HEIGHT: prdata = DATA_W'(cfg.img_h);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dtpc_ctrl.sv =====
// sequencer for one pixel: takes the request, steps the shared multiplier,
// orders the rounding and the output load; depends on dtpc_pkg
`default_nettype none

module dtpc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               enable,
  input  wire dtpc_pkg::status_t  status,
  output dtpc_pkg::cmd_t          cmd
);
  import dtpc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HX0  = 3'd1;
  localparam logic [2:0] ST_HX1  = 3'd2;
  localparam logic [2:0] ST_HX2  = 3'd3;
  localparam logic [2:0] ST_VX0  = 3'd4;
  localparam logic [2:0] ST_VX1  = 3'd5;
  localparam logic [2:0] ST_VX2  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       take;

  assign in_stall = (state != ST_IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.start    = take;
    case (state)
      ST_IDLE: begin
        if (take && enable) state_next = ST_HX0;
      end
      ST_HX0: begin
        cmd.mul_en = 1'b1; cmd.axis = AX_H; cmd.phase = PH_OFF;
        state_next = ST_HX1;
      end
      ST_HX1: begin
        cmd.mul_en = 1'b1; cmd.axis = AX_H; cmd.phase = PH_LO;
        state_next = ST_HX2;
      end
      ST_HX2: begin
        cmd.mul_en = 1'b1; cmd.axis = AX_H; cmd.phase = PH_HI;
        state_next = ST_VX0;
      end
      ST_VX0: begin
        cmd.mul_en = 1'b1; cmd.axis = AX_V; cmd.phase = PH_OFF;
        cmd.y_load = 1'b1;
        state_next = ST_VX1;
      end
      ST_VX1: begin
        cmd.mul_en = 1'b1; cmd.axis = AX_V; cmd.phase = PH_LO;
        state_next = ST_VX2;
      end
      ST_VX2: begin
        cmd.mul_en = 1'b1; cmd.axis = AX_V; cmd.phase = PH_HI;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!status.out_blocked) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_disabled_idle: assert property (@(posedge clk) disable iff (rst)
    take && !enable |=> state == ST_IDLE)
    else $error("disabled pixel started a computation");

  a_enabled_start: assert property (@(posedge clk) disable iff (rst)
    take && enable |=> state == ST_HX0)
    else $error("enabled pixel did not start the multiplier sequence");

  a_fin_release: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && !status.out_blocked |=> state == ST_IDLE)
    else $error("finished pixel did not release the input");

endmodule

`default_nettype wire

// ===== hw/rtl/dtpc_dp.sv =====
// datapath: position counters, distance lookup, shared multiplier,
// rounding and saturation, output register; depends on dtpc_pkg
`default_nettype none

module dtpc_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire dtpc_pkg::cfg_t                        cfg,
  input  wire dtpc_pkg::cmd_t                        cmd,
  output dtpc_pkg::status_t                          status,
  input  wire logic [dtpc_pkg::CODE_W-1:0]           depth_code,
  input  wire logic                                  frame_start,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [dtpc_pkg::COORD_W-1:0]        x_pos,
  output logic signed [dtpc_pkg::COORD_W-1:0]        y_pos,
  output logic signed [dtpc_pkg::COORD_W-1:0]        z_pos,
  output logic                                       point_valid,
  output logic                                       end_of_frame
);
  import dtpc_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WDW  = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int HDW  = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam int PMAX = (CW > RW) ? CW : RW;
  localparam int UW   = (PMAX + 4 > CTR_W) ? PMAX + 4 : CTR_W;
  localparam int OFFW = UW + 1;
  localparam int AW   = DIST_W + OFFW;
  localparam int BW   = (OFFW > INV_HALF + 1) ? OFFW : INV_HALF + 1;
  localparam int MW   = AW + BW;
  localparam int PW   = AW + INV_W;

  localparam logic [WDW-1:0] W_MAX = WDW'(MAX_WIDTH);
  localparam logic [HDW-1:0] H_MAX = HDW'(MAX_HEIGHT);
  localparam logic signed [PW:0] RND_HALF = (PW+1)'(1) <<< 27;
  localparam logic signed [PW:0] SAT_HI   = (PW+1)'(COORD_MAX);
  localparam logic signed [PW:0] SAT_LO   = (PW+1)'(COORD_MIN);

  // position
  logic [CW-1:0]  col_cnt;
  logic [RW-1:0]  row_cnt;
  logic [CW-1:0]  col_cur;
  logic [RW-1:0]  row_cur;
  logic [WDW-1:0] w_lim;
  logic [HDW-1:0] h_lim;
  logic           last_col;
  logic           last_row;

  // latched pixel
  logic [DIST_W-1:0]      distance;
  logic                   pv;
  logic                   eof;
  logic signed [OFFW-1:0] off_h;
  logic signed [OFFW-1:0] off_v;

  // multiplier
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [MW-1:0] mul;
  logic signed [AW-1:0] pa;
  logic signed [PW-1:0] acc;
  logic [COORD_W-1:0]   y_hold;
  logic [INV_W-1:0]     inv_sel;

  function automatic logic [COORD_W-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW:0] s;
    logic signed [PW:0] q;
    s = RND_HALF - (PW+1)'(p);
    q = s >>> 28;
    if (q > SAT_HI) begin
      return COORD_W'(SAT_HI);
    end else if (q < SAT_LO) begin
      return COORD_W'(SAT_LO);
    end
    return q[COORD_W-1:0];
  endfunction

  always_comb begin
    col_cur = frame_start ? '0 : col_cnt;
    row_cur = frame_start ? '0 : row_cnt;
    if (cfg.img_w == '0) begin
      w_lim = WDW'(1);
    end else if (WDW'(cfg.img_w) > W_MAX) begin
      w_lim = W_MAX;
    end else begin
      w_lim = WDW'(cfg.img_w);
    end
    if (cfg.img_h == '0) begin
      h_lim = HDW'(1);
    end else if (HDW'(cfg.img_h) > H_MAX) begin
      h_lim = H_MAX;
    end else begin
      h_lim = HDW'(cfg.img_h);
    end
    last_col = WDW'(col_cur) >= w_lim - WDW'(1);
    last_row = HDW'(row_cur) >= h_lim - HDW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cmd.start) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cur + RW'(1);
      end else begin
        col_cnt <= col_cur + CW'(1);
        row_cnt <= row_cur;
      end
    end
  end

  // pixel latch: offsets in 1/16 pixel
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      distance <= DIST_LUT[depth_code];
      pv       <= (depth_code != CODE_NONE);
      eof      <= last_col && last_row;
      off_h    <= signed'(OFFW'({col_cur, 4'b0000})) - signed'(OFFW'(cfg.ctr_u));
      off_v    <= signed'(OFFW'({row_cur, 4'b0000})) - signed'(OFFW'(cfg.ctr_v));
    end
  end

  // shared multiplier operand selection
  always_comb begin
    inv_sel = (cmd.axis == AX_V) ? cfg.inv_fy : cfg.inv_fx;
    case (cmd.phase)
      PH_OFF: begin
        a_op = signed'(AW'(distance));
        b_op = (cmd.axis == AX_V) ? BW'(off_v) : BW'(off_h);
      end
      PH_LO: begin
        a_op = pa;
        b_op = signed'(BW'(inv_sel[INV_HALF-1:0]));
      end
      PH_HI: begin
        a_op = pa;
        b_op = signed'(BW'(inv_sel[INV_W-1:INV_HALF]));
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign mul = a_op * b_op;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.phase)
        PH_OFF:  pa  <= mul[AW-1:0];
        PH_LO:   acc <= PW'(mul);
        PH_HI:   acc <= acc + (PW'(mul) <<< INV_HALF);
        default: ;
      endcase
    end
    if (cmd.y_load) begin
      y_hold <= round_sat(acc);
    end
  end

  assign status.out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      x_pos        <= pv ? signed'(COORD_W'(distance)) : '0;
      y_pos        <= pv ? signed'(y_hold) : '0;
      z_pos        <= pv ? signed'(round_sat(acc)) : '0;
      point_valid  <= pv;
      end_of_frame <= eof;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output register overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded point not presented");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> x_pos == '0 && y_pos == '0 && z_pos == '0)
    else $error("invalid point carries nonzero coordinates");

endmodule

`default_nettype wire

// ===== verif/dtpc_point_checker.sv =====
// point checker for the depth to point cloud block: tracks the register writes,
// predicts each point from the accepted pixel requests and compares field by field
// depends on dtpc_pkg
`default_nettype none

module dtpc_point_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [dtpc_pkg::CODE_W-1:0]         depth_code,
  input  wire logic                                frame_start,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [dtpc_pkg::COORD_W-1:0] x_pos,
  input  wire logic signed [dtpc_pkg::COORD_W-1:0] y_pos,
  input  wire logic signed [dtpc_pkg::COORD_W-1:0] z_pos,
  input  wire logic                                point_valid,
  input  wire logic                                end_of_frame,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic                                pready,
  input  wire logic [dtpc_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [dtpc_pkg::DATA_W-1:0]         pwdata,
  output int                                       mismatches,
  output int                                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import dtpc_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] z_pos;
    logic                      point_valid;
    logic                      end_of_frame;
  } point_t;

  localparam longint RangeDiv   = 26010;
  localparam longint RangeRound = 13005;

  cfg_t   shadow_cfg;
  point_t expected_points[$];
  int     col_pos;
  int     row_pos;
  int     err_count = 0;

  function automatic int dim_in_use(logic [DIM_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic logic signed [COORD_W-1:0] to_coord(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    else if (v < COORD_MIN) v = COORD_MIN;
    return COORD_W'(v);
  endfunction

  // -distance * (pos - center) / f, offset in 1/16 pixel, inverse focal in 2^-24
  function automatic logic signed [COORD_W-1:0] back_project(longint distance, int pos,
                                                            logic [CTR_W-1:0] center,
                                                            logic [INV_W-1:0] inv_f);
    longint offset;
    longint prod;
    offset = longint'(pos) * 16 - longint'(center);
    prod   = distance * offset * longint'(inv_f);
    return to_coord((-prod + (longint'(1) << 27)) >>> 28);
  endfunction

  function automatic point_t project_pixel(logic [CODE_W-1:0] code, int col, int row,
                                           logic last_pixel);
    point_t p;
    longint distance;
    p = '0;
    p.end_of_frame = last_pixel;
    if (code != CODE_NONE) begin
      distance = (longint'(code) * longint'(code) * 65536 + RangeRound) / RangeDiv;
      p.x_pos = to_coord(distance);
      p.y_pos = back_project(distance, col, shadow_cfg.ctr_u, shadow_cfg.inv_fx);
      p.z_pos = back_project(distance, row, shadow_cfg.ctr_v, shadow_cfg.inv_fy);
      p.point_valid = 1'b1;
    end
    return p;
  endfunction

  function automatic int field_differs(string field, longint want, longint got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    point_t want;
    int     w;
    int     h;
    logic   last_col;
    logic   last_row;
    if (rst) begin
      shadow_cfg = '{enable: 1'b0, inv_fx: INV_F_RST, inv_fy: INV_F_RST,
                     ctr_u: CTR_RST, ctr_v: CTR_RST, img_w: DIM_RST, img_h: DIM_RST};
      expected_points.delete();
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_ENABLE: shadow_cfg.enable = pwdata[0];
          REG_INV_FX: shadow_cfg.inv_fx = pwdata[INV_W-1:0];
          REG_INV_FY: shadow_cfg.inv_fy = pwdata[INV_W-1:0];
          REG_CTR_U:  shadow_cfg.ctr_u  = pwdata[CTR_W-1:0];
          REG_CTR_V:  shadow_cfg.ctr_v  = pwdata[CTR_W-1:0];
          REG_WIDTH:  shadow_cfg.img_w  = pwdata[DIM_W-1:0];
          REG_HEIGHT: shadow_cfg.img_h  = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end

      // a point leaving now belongs to an earlier pixel, so pop before push
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("point request with no pixel waiting for it");
          err_count++;
        end else begin
          want = expected_points.pop_front();
          err_count += field_differs("x_pos", want.x_pos, x_pos);
          err_count += field_differs("y_pos", want.y_pos, y_pos);
          err_count += field_differs("z_pos", want.z_pos, z_pos);
          err_count += field_differs("point_valid", want.point_valid, point_valid);
          err_count += field_differs("end_of_frame", want.end_of_frame, end_of_frame);
        end
      end

      if (in_valid && !in_stall) begin
        if (frame_start) begin
          col_pos = 0;
          row_pos = 0;
        end
        w = dim_in_use(shadow_cfg.img_w, MAX_WIDTH);
        h = dim_in_use(shadow_cfg.img_h, MAX_HEIGHT);
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        if (shadow_cfg.enable)
          expected_points.push_back(project_pixel(depth_code, col_pos, row_pos,
                                                  last_col && last_row));
        if (last_col) begin
          col_pos = 0;
          row_pos = last_row ? 0 : row_pos + 1;
        end else begin
          col_pos = col_pos + 1;
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= expected_points.size();
  end

endmodule

`default_nettype wire

// ===== verif/depth_to_point_cloud_tb.sv =====
// testbench top for depth_to_point_cloud: clock, reset, apb register writes,
// pixel requests and output stalls; checking sits in dtpc_point_checker
// depends on dtpc_pkg, depth_to_point_cloud and dtpc_point_checker
`default_nettype none

module depth_to_point_cloud_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtpc_pkg::*;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // no register behind this index, a write there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  // extra wait after the drain to cover any pixel still in flight
  localparam int SETTLE_CYCLES = 12;
  // points to produce in the random part, the last stretch runs without idling
  localparam int RANDOM_POINTS = 440;
  localparam int QUIET_POINTS  = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // every input starts at a known value
  logic                      in_valid    = 1'b0;
  logic [CODE_W-1:0]         depth_code  = '0;
  logic                      frame_start = 1'b0;
  logic                      out_stall   = 1'b0;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [ADDR_W-1:0]         paddr       = '0;
  logic [DATA_W-1:0]         pwdata      = '0;

  logic                      in_stall;
  logic                      out_valid;
  logic signed [COORD_W-1:0] x_pos;
  logic signed [COORD_W-1:0] y_pos;
  logic signed [COORD_W-1:0] z_pos;
  logic                      point_valid;
  logic                      end_of_frame;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int mismatches;
  int outstanding;

  // stimulus shaping
  logic quiet     = 1'b0;  // no idling on either side once set
  int   gap_odds  = 4;     // one request in gap_odds is preceded by a gap, 0 means none
  int   hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  depth_to_point_cloud #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .depth_code  (depth_code),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .z_pos       (z_pos),
    .point_valid (point_valid),
    .end_of_frame(end_of_frame),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dtpc_point_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .depth_code  (depth_code),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .z_pos       (z_pos),
    .point_valid (point_valid),
    .end_of_frame(end_of_frame),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // output side: stall bursts alternate with free runs of varying length,
  // now and then a long free run so some stretches see no back-pressure at all
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      hold_left <= ($urandom_range(7) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30);
    end else begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(0, 16);
    end
  end

  // hard limit, far above the slowest legal run
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // apb write: setup phase, access phase, then an idle phase so that a following
  // write never lowers and raises psel in the same step
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setup(input logic [DATA_W-1:0] en, input logic [DATA_W-1:0] ifx,
                             input logic [DATA_W-1:0] ify, input logic [DATA_W-1:0] cu,
                             input logic [DATA_W-1:0] cv, input logic [DATA_W-1:0] w,
                             input logic [DATA_W-1:0] h);
    write_reg(REG_ENABLE, en);
    write_reg(REG_INV_FX, ifx);
    write_reg(REG_INV_FY, ify);
    write_reg(REG_CTR_U, cu);
    write_reg(REG_CTR_V, cv);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // one pixel request; a gap or a full drain may come first, and time always
  // passes after in_valid is lowered so it is never dropped and raised in one step
  task automatic send_pixel(input logic [CODE_W-1:0] code, input logic fs);
    if (!quiet && gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end else if (!quiet && $urandom_range(79) == 0) begin
      // hold off until every point in flight has come out
      in_valid <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
    end
    in_valid    <= 1'b1;
    depth_code  <= code;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // block idle: no request pending, every expected point out, pipeline empty
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_focal();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'h00FF_FFFF;
      2: return DATA_W'(INV_F_RST);
      3: return $urandom;  // bits above the register are dropped
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_center();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'h3FFF;
      2: return DATA_W'(CTR_RST);
      3: return $urandom;
      default: return $urandom_range(0, 32'h3FFF);
    endcase
  endfunction

  // mostly small frames so that frame ends come often
  function automatic logic [DATA_W-1:0] pick_dim();
    case ($urandom_range(15))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int dim_span(logic [DATA_W-1:0] v, int limit);
    if (v[DIM_W-1:0] == '0) return 1;
    if (int'(v[DIM_W-1:0]) > limit) return limit;
    return int'(v[DIM_W-1:0]);
  endfunction

  initial begin
    logic [DATA_W-1:0] en;
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] h;
    logic [CODE_W-1:0] code;
    logic              fs;
    logic              fresh_frame;
    int                points_sent;
    int                frame_len;
    int                n_items;

    points_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset: nothing comes out, the position still moves
    send_pixel(8'd40, 1'b1);
    send_pixel(8'd200, 1'b0);
    send_pixel(CODE_NONE, 1'b0);
    wait_for_drain();

    // zero width means one pixel per row, principal point at the far corner with the
    // steepest x focal saturates y; zero y focal flattens z
    apply_setup(1, 32'h00FF_FFFF, 0, 32'h3FFF, 0, 0, 3);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd254, 1'b0);
    send_pixel(CODE_NONE, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd254, 1'b0);
    send_pixel(CODE_NONE, 1'b0);
    wait_for_drain();

    // oversized width is cut to 1024: walk the row with points off, then look at its
    // last columns, where y saturates negative and z positive, and the next row's start
    apply_setup(0, 32'h00FF_FFFF, 32'h00FF_FFFF, 0, 32'h3FFF, 32'h7FF, 2);
    send_pixel(8'd3, 1'b1);
    repeat (1021) send_pixel(CODE_W'($urandom_range(0, 255)), 1'b0);
    wait_for_drain();
    write_reg(REG_ENABLE, 1);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd77, 1'b0);
    wait_for_drain();

    // frame shrunk under the counters: both already past the new last index,
    // so the next pixel ends the frame and the position wraps
    apply_setup(0, DATA_W'(INV_F_RST), DATA_W'(INV_F_RST), DATA_W'(CTR_RST),
                DATA_W'(CTR_RST), 20, 8);
    send_pixel(8'd50, 1'b1);
    repeat (114) send_pixel(CODE_W'($urandom_range(0, 255)), 1'b0);
    wait_for_drain();
    write_reg(REG_WIDTH, 5);
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_ENABLE, 1);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd101, 1'b0);
    send_pixel(8'd102, 1'b0);
    wait_for_drain();

    // a write past the last register must leave everything as it was
    write_reg(REG_SPARE, $urandom);
    send_pixel(8'd60, 1'b0);
    send_pixel(CODE_NONE, 1'b0);
    points_sent = 15;

    // random part: one setting per phase, mostly whole frames marked by frame_start,
    // with stray frame starts and phases that pick up a frame in the middle
    while (points_sent < RANDOM_POINTS) begin
      wait_for_drain();
      if (points_sent >= RANDOM_POINTS - QUIET_POINTS) quiet <= 1'b1;
      en = ($urandom_range(7) != 0) ? 32'd1 : {$urandom} & ~32'd1;
      w  = pick_dim();
      h  = pick_dim();
      apply_setup(en, pick_focal(), pick_focal(), pick_center(), pick_center(), w, h);
      gap_odds    = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 8);
      frame_len   = dim_span(w, MAX_WIDTH) * dim_span(h, MAX_HEIGHT);
      fresh_frame = ($urandom_range(3) != 0);
      n_items     = $urandom_range(10, 60);
      for (int k = 0; k < n_items; k++) begin
        fs = ((k % frame_len) == 0 && (k != 0 || fresh_frame)) || ($urandom_range(24) == 0);
        case ($urandom_range(9))
          0: code = CODE_NONE;
          1: code = 8'd0;
          2: code = 8'd254;
          default: code = CODE_W'($urandom_range(0, 255));
        endcase
        send_pixel(code, fs);
        if (en[0]) points_sent++;
      end
    end

    // let every point out, then allow the pipeline to go quiet
    in_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 20000 && outstanding != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== depth_to_point_cloud.f =====
hw/rtl/dtpc_pkg.sv
hw/rtl/dtpc_regs.sv
hw/rtl/dtpc_ctrl.sv
hw/rtl/dtpc_dp.sv
hw/rtl/depth_to_point_cloud.sv
verif/dtpc_point_checker.sv
verif/depth_to_point_cloud_tb.sv
